// ===== rtl/totd_pkg.sv =====
// -----------------------------------------------------------------------------
// totd_pkg
// Shared types and constants for the time-over-threshold timestamp digitizer.
// -----------------------------------------------------------------------------
package totd_pkg;

	// Field widths
	localparam int SAMPLE_W = 16;
	localparam int TIME_W   = 16;
	localparam int TICK_W   = TIME_W + 1;
	localparam int P1_W     = 10;
	localparam int P2_W     = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TS1_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TS2_PERIOD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG      = 2'd3;

	// Configuration reset values
	localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RST = 16'sd35;
	localparam logic [P1_W-1:0]            TS1_PERIOD_RST = 10'd8;
	localparam logic [P2_W-1:0]            TS2_PERIOD_RST = 12'd128;
	localparam logic [TIME_W-1:0]          INTEG_RST      = 16'd5000;

	// Hit phases
	localparam logic [1:0] PH_SEARCH = 2'd0;
	localparam logic [1:0] PH_TRACK  = 2'd1;
	localparam logic [1:0] PH_MISS   = 2'd2;
	localparam logic [1:0] PH_HIT    = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] threshold;
		logic [P1_W-1:0]            ts1_period;
		logic [P2_W-1:0]            ts2_period;
		logic [TIME_W-1:0]          integration_ticks;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [TIME_W-1:0]          tot_cap;
		logic                       last;
	} item_t;

	typedef struct packed {
		logic              crossed;
		logic [TIME_W-1:0] ts1;
		logic [TIME_W-1:0] ts2;
	} result_t;

endpackage

// ===== rtl/totd_cfg.sv =====
// -----------------------------------------------------------------------------
// totd_cfg
// Configuration register file; accepts one write transaction per cycle.
// -----------------------------------------------------------------------------
module totd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [totd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [totd_pkg::CFG_DAT_W-1:0] cfg_data,
	output totd_pkg::cfg_t                 cfg
);
	import totd_pkg::*;

	cfg_t cfg_q;

	// The register file never stalls a write.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes, truncated to each register's width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold         <= THRESHOLD_RST;
			cfg_q.ts1_period        <= TS1_PERIOD_RST;
			cfg_q.ts2_period        <= TS2_PERIOD_RST;
			cfg_q.integration_ticks <= INTEG_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_THRESHOLD:  cfg_q.threshold         <= $signed(cfg_data);
				REG_TS1_PERIOD: cfg_q.ts1_period        <= cfg_data[P1_W-1:0];
				REG_TS2_PERIOD: cfg_q.ts2_period        <= cfg_data[P2_W-1:0];
				REG_INTEG:      cfg_q.integration_ticks <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/totd_core.sv =====
// -----------------------------------------------------------------------------
// totd_core
// Per-hit state and the single-pass update that handles one sample.
// -----------------------------------------------------------------------------
module totd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  totd_pkg::item_t   item,
	input  totd_pkg::cfg_t    cfg,
	output totd_pkg::result_t result
);
	import totd_pkg::*;

	logic [TICK_W-1:0] tick_q;
	logic [1:0]        phase_q;
	logic [TIME_W-1:0] fc_q;
	logic [TICK_W-1:0] fnt_q;
	logic [TIME_W-1:0] cc_q;
	logic [TICK_W-1:0] cnt_q;
	logic [TICK_W-1:0] cet_q;
	logic              still_q;
	logic [TIME_W-1:0] edge_q;
	logic [TIME_W-1:0] cap_q;

	logic [TICK_W-1:0] n_tick;
	logic [1:0]        n_phase;
	logic [TIME_W-1:0] n_fc;
	logic [TICK_W-1:0] n_fnt;
	logic [TIME_W-1:0] n_cc;
	logic [TICK_W-1:0] n_cnt;
	logic [TICK_W-1:0] n_cet;
	logic              n_still;
	logic [TIME_W-1:0] n_edge;
	logic [TIME_W-1:0] n_cap;

	logic [P1_W-1:0]   p1;
	logic [P2_W-1:0]   p2;
	logic [TICK_W-1:0] win;
	logic [TICK_W-1:0] cap_sum;
	logic [TICK_W-1:0] fine_step;
	logic [TICK_W-1:0] coarse_step;
	logic              above;
	logic              below;
	logic              thr_pos;
	logic              crossed;

	// Threshold polarity: a positive threshold looks for samples above it.
	always_comb begin
		thr_pos = cfg.threshold > 16'sd0;
		above   = thr_pos ? (item.sample > cfg.threshold) : (item.sample < cfg.threshold);
		below   = thr_pos ? (item.sample < cfg.threshold) : (item.sample > cfg.threshold);
	end

	// Next-state logic: crossing search followed by trailing-edge tracking.
	always_comb begin
		p1  = (cfg.ts1_period == '0) ? P1_W'(1) : cfg.ts1_period;
		p2  = (cfg.ts2_period == '0) ? P2_W'(1) : cfg.ts2_period;
		win = {1'b0, cfg.integration_ticks};

		n_tick  = (tick_q != '1) ? tick_q + TICK_W'(1) : tick_q;
		n_phase = phase_q;
		n_fc    = fc_q;
		n_fnt   = fnt_q;
		n_cc    = cc_q;
		n_cnt   = cnt_q;
		n_cet   = cet_q;
		n_still = still_q;
		n_edge  = edge_q;
		n_cap   = (tick_q == '0) ? item.tot_cap : cap_q;

		cap_sum     = fnt_q + {1'b0, n_cap};
		fine_step   = fnt_q + TICK_W'(p1);
		coarse_step = '0;

		// Search the fine grid for the first sample above threshold.
		if (phase_q == PH_SEARCH) begin
			if (fnt_q >= win) begin
				n_phase = PH_MISS;
			end else if (tick_q >= fnt_q) begin
				if (above) begin
					n_cet   = (cap_sum < win) ? cap_sum : win;
					n_phase = PH_TRACK;
				end else begin
					n_fc  = fc_q + TIME_W'(1);
					n_fnt = fine_step;
					if (fine_step >= win) begin
						n_phase = PH_MISS;
					end
				end
			end
			// Keep the coarse point at the first grid time not below the tick.
			if (n_phase != PH_TRACK && cnt_q <= tick_q) begin
				n_cc  = cc_q + TIME_W'(1);
				n_cnt = cnt_q + TICK_W'(p2);
			end
		end

		// Track the trailing edge on the coarse grid.
		if (n_phase == PH_TRACK) begin
			coarse_step = n_cnt + TICK_W'(p2);
			if (n_cnt >= n_cet) begin
				n_phase = PH_HIT;
			end else if (tick_q >= n_cnt) begin
				if (still_q && below) begin
					n_edge  = n_cc;
					n_still = 1'b0;
				end else if (!still_q && !below) begin
					n_still = 1'b1;
				end
				n_cc  = n_cc + TIME_W'(1);
				n_cnt = coarse_step;
				if (coarse_step >= n_cet) begin
					n_phase = PH_HIT;
				end
			end
		end

		// Result seen on the last sample of the hit.
		crossed        = (n_phase == PH_TRACK) || (n_phase == PH_HIT);
		result.crossed = crossed;
		result.ts1     = n_fc;
		if (!crossed) begin
			result.ts2 = '0;
		end else if (n_still) begin
			result.ts2 = (n_cc != '0) ? n_cc - TIME_W'(1) : '0;
		end else begin
			result.ts2 = n_edge;
		end
	end

	// State update; the last sample returns the hit state to its start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			phase_q <= PH_SEARCH;
			fc_q    <= '0;
			fnt_q   <= '0;
			cc_q    <= '0;
			cnt_q   <= '0;
			cet_q   <= '0;
			still_q <= 1'b1;
			edge_q  <= '0;
			cap_q   <= '0;
		end else if (adv) begin
			if (item.last) begin
				tick_q  <= '0;
				phase_q <= PH_SEARCH;
				fc_q    <= '0;
				fnt_q   <= '0;
				cc_q    <= '0;
				cnt_q   <= '0;
				cet_q   <= '0;
				still_q <= 1'b1;
				edge_q  <= '0;
				cap_q   <= '0;
			end else begin
				tick_q  <= n_tick;
				phase_q <= n_phase;
				fc_q    <= n_fc;
				fnt_q   <= n_fnt;
				cc_q    <= n_cc;
				cnt_q   <= n_cnt;
				cet_q   <= n_cet;
				still_q <= n_still;
				edge_q  <= n_edge;
				cap_q   <= n_cap;
			end
		end
	end

	// A finished hit leaves the state ready for the next one.
	a_hit_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item.last |=> tick_q == '0 && phase_q == PH_SEARCH && still_q)
		else $error("hit state not cleared after last sample");

	// Once the search is over, the fine count no longer moves.
	a_fine_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !item.last && phase_q != PH_SEARCH |=> $stable(fc_q))
		else $error("fine count moved after the search ended");

	// A trailing-edge count is only reported for a crossed hit.
	a_ts2_needs_cross: assert property (@(posedge clk) disable iff (!arst_n)
		!result.crossed |-> result.ts2 == '0)
		else $error("ts2 nonzero without a crossing");

endmodule

// ===== rtl/tot_timestamp_digitizer.sv =====
// -----------------------------------------------------------------------------
// tot_timestamp_digitizer
// Time-over-threshold digitizer: gives the crossing and trailing-edge counts
// of a hit on the transaction that carries its last sample.
// -----------------------------------------------------------------------------
// The result of a hit is registered in the result register once its last sample leaves the input register.
// Throughput: one sample per cycle while the stage is not stalled; the per-hit state is updated in
// one pass between the input register and the result register.
// A result waiting in the output register stalls input only for a last sample.
// Reset (arst_n low) clears the hit state, the pipeline valids and restores
// the configuration registers to their defaults.
module tot_timestamp_digitizer (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [31:0]                    s_tdata,  // [15:0] sample, [31:16] tot_cap
	input  logic                           s_tlast,
	// Result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,  // [15:0] ts1, [31:16] ts2
	output logic                           m_tuser,  // [0] crossed
	// Configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [totd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [totd_pkg::CFG_DAT_W-1:0] cfg_data
);
	import totd_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    adv;
	result_t result;
	result_t out_q;
	logic    out_valid_q;

	totd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The stage moves unless a last sample would overwrite a waiting result.
	assign adv      = valid_s1 && (!item_s1.last || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.sample  <= $signed(s_tdata[SAMPLE_W-1:0]);
			item_s1.tot_cap <= s_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W];
			item_s1.last    <= s_tlast;
		end
	end

	totd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && item_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && item_s1.last) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.ts2, out_q.ts1};
	assign m_tuser  = out_q.crossed;

	// Input is held back only while the stage holds a last sample blocked by a waiting result.
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && item_s1.last && out_valid_q && !m_tready)
		else $error("input stalled without a blocked last sample");

	// Every last sample that leaves the stage raises a result.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.last |=> m_tvalid)
		else $error("last sample produced no result");

	// A sample that is not last never raises a result.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid ##1 m_tvalid |-> $past(adv && item_s1.last))
		else $error("result appeared without a last sample");

endmodule
